// ===== src/uerc_pkg.sv =====
// shared types and constants for the ultrasonic echo ranging controller
// no dependencies; imported by every other file of the block
package uerc_pkg;

   // default parameter values
   localparam int COUNT_BITS_DEF    = 16;
   localparam int SCALE_DIVISOR_DEF = 18500;

   // configuration port
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_HOLDOFF   = 3'd0,
      CSR_TRIGGER   = 3'd1,
      CSR_MIN_WIDTH = 3'd2,
      CSR_TIMEOUT   = 3'd3,
      CSR_MULT      = 3'd4,
      CSR_OFFSET    = 3'd5
   } csr_index_type;

   // register reset values
   localparam logic [15:0] HOLDOFF_RST   = 16'd200;
   localparam logic [7:0]  TRIGGER_RST   = 8'd5;
   localparam logic [15:0] MIN_WIDTH_RST = 16'd115;
   localparam logic [15:0] TIMEOUT_RST   = 16'd18500;
   localparam logic [11:0] MULT_RST      = 12'd3000;
   localparam logic [7:0]  OFFSET_RST    = 8'd10;

   typedef struct packed {
      logic [15:0] holdoff_ticks;
      logic [7:0]  trigger_ticks;
      logic [15:0] min_width;
      logic [15:0] timeout_ticks;
      logic [11:0] scale_mult;
      logic [7:0]  dist_offset;
   } cfg_type;

   // result fields
   localparam int STATUS_BITS = 2;
   localparam int DIST_BITS   = 8;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_RANGE   = 2'd0,
      ST_SHORT   = 2'd1,
      ST_TIMEOUT = 2'd2
   } status_type;

   localparam logic [DIST_BITS-1:0] DIST_MAX    = 8'hFF;
   localparam logic [DIST_BITS-1:0] LED_OFF     = 8'hFF;
   localparam logic [DIST_BITS-1:0] LED_NO_ECHO = 8'h7F;

   // what the front end decided for one tick
   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_RANGE,
      KIND_SHORT,
      KIND_TIMEOUT
   } kind_type;

   typedef struct packed {
      logic     trig;
      kind_type kind;
   } ctl_type;

   localparam int CTL_BITS = $bits(ctl_type);

   localparam int QUEUE_DEPTH = 4;

endpackage

// ===== src/uerc_if.sv =====
// handshake channel interfaces for the echo ranging controller
// depends on uerc_pkg
interface uerc_req_if;
   logic valid;
   logic ready;
   logic echo_level;

   modport source (output valid, output echo_level, input ready);
   modport sink   (input valid, input echo_level, output ready);
endinterface

interface uerc_rsp_if;
   import uerc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   trigger_level;
   logic                   result_valid;
   logic [STATUS_BITS-1:0] status;
   logic [DIST_BITS-1:0]   distance;
   logic [DIST_BITS-1:0]   led_pattern;

   modport source (output valid, output trigger_level, output result_valid, output status,
                   output distance, output led_pattern, input ready);
   modport sink   (input valid, input trigger_level, input result_valid, input status,
                   input distance, input led_pattern, output ready);
endinterface

// ===== src/uerc_front.sv =====
// front end: per-tick episode sequencer (holdoff, trigger, wait, measure)
// classifies each tick and hands the echo width on; depends on uerc_pkg
module uerc_front #(
   parameter int COUNT_BITS = uerc_pkg::COUNT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  uerc_pkg::cfg_type       cfg,
   input  logic                    step,
   input  logic                    echo,
   output uerc_pkg::ctl_type       ctl,
   output logic [COUNT_BITS-1:0]   width
);
   import uerc_pkg::*;

   typedef enum logic [1:0] {
      PH_HOLDOFF,
      PH_TRIGGER,
      PH_WAIT,
      PH_MEASURE
   } phase_type;

   localparam int CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

   phase_type             phase_ff, phase_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                  last_ff;

   logic [COUNT_BITS-1:0] cnt_p1, cnt_sat;
   logic [CMP_BITS-1:0]   cnt_x, cnt_sat_x;

   always_comb begin
      cnt_p1    = cnt_ff + CNT_ONE;
      cnt_sat   = (cnt_ff == CNT_MAX) ? CNT_MAX : cnt_p1;
      cnt_x     = CMP_BITS'(cnt_ff);
      cnt_sat_x = CMP_BITS'(cnt_sat);
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      ctl.trig  = 1'b0;
      ctl.kind  = KIND_NONE;
      width     = cnt_ff;
      case (phase_ff)
         PH_HOLDOFF: begin
            if (cnt_x < CMP_BITS'(cfg.holdoff_ticks) && cnt_ff != CNT_MAX) begin
               cnt_in = cnt_p1;
            end else begin
               // first trigger tick follows on the same tick
               ctl.trig = 1'b1;
               if (cfg.trigger_ticks <= 8'd1) begin
                  phase_in = PH_WAIT;
                  cnt_in   = '0;
               end else begin
                  phase_in = PH_TRIGGER;
                  cnt_in   = CNT_ONE;
               end
            end
         end
         PH_TRIGGER: begin
            ctl.trig = 1'b1;
            if (CMP_BITS'(cnt_p1) >= CMP_BITS'(cfg.trigger_ticks)) begin
               phase_in = PH_WAIT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_p1;
            end
         end
         PH_WAIT: begin
            // rising edge tick is the first high tick of the width
            if (echo && !last_ff) begin
               if (cfg.timeout_ticks <= 16'd1) begin
                  ctl.kind = KIND_TIMEOUT;
                  phase_in = PH_HOLDOFF;
                  cnt_in   = '0;
               end else begin
                  phase_in = PH_MEASURE;
                  cnt_in   = CNT_ONE;
               end
            end
         end
         PH_MEASURE: begin
            if (!echo) begin
               ctl.kind = (cnt_x < CMP_BITS'(cfg.min_width)) ? KIND_SHORT : KIND_RANGE;
               phase_in = PH_HOLDOFF;
               cnt_in   = '0;
            end else if (cnt_sat_x >= CMP_BITS'(cfg.timeout_ticks) || cnt_sat == CNT_MAX) begin
               ctl.kind = KIND_TIMEOUT;
               phase_in = PH_HOLDOFF;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_sat;
            end
         end
         default: begin
            phase_in = PH_HOLDOFF;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HOLDOFF;
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         last_ff  <= echo;
      end
   end

endmodule

// ===== src/uerc_queue.sv =====
// short fifo between the tick sequencer and the distance pipeline
// register based, power-of-two depth from uerc_pkg
module uerc_queue #(
   parameter int DATA_BITS = uerc_pkg::CTL_BITS + uerc_pkg::COUNT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output logic [DATA_BITS-1:0] pop_data
);
   import uerc_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   logic [DATA_BITS-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]    count_ff;

   assign full      = (count_ff == (PTR_BITS + 1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (PTR_BITS + 1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (PTR_BITS + 1)'(1);
         end
      end
   end

endmodule

// ===== src/uerc_back.sv =====
// back end: distance pipeline (width*mult, reciprocal divide, correct, clamp)
// and result register with the held display byte; depends on uerc_pkg
module uerc_back #(
   parameter int COUNT_BITS    = uerc_pkg::COUNT_BITS_DEF,
   parameter int SCALE_DIVISOR = uerc_pkg::SCALE_DIVISOR_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  uerc_pkg::cfg_type              cfg,
   input  logic                           in_valid,
   input  uerc_pkg::ctl_type              in_ctl,
   input  logic [COUNT_BITS-1:0]          in_width,
   output logic                           in_ready,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic                           out_trigger,
   output logic                           out_result,
   output logic [uerc_pkg::STATUS_BITS-1:0] out_status,
   output logic [uerc_pkg::DIST_BITS-1:0] out_distance,
   output logic [uerc_pkg::DIST_BITS-1:0] out_led
);
   import uerc_pkg::*;

   localparam int PROD_BITS = COUNT_BITS + 12;
   // quotients of 256 and above all clamp, so only products below 256*divisor matter
   localparam int PL_BITS   = $clog2(256 * SCALE_DIVISOR);
   localparam int EXT_BITS  = (PROD_BITS > PL_BITS) ? PROD_BITS : PL_BITS;
   localparam int R_BITS    = PL_BITS + 1;
   localparam int EST_BITS  = PL_BITS + R_BITS;
   localparam logic [EXT_BITS-1:0] LIM_X  = EXT_BITS'(256 * SCALE_DIVISOR);
   localparam logic [R_BITS-1:0]   RECIP  = R_BITS'((64'd1 << PL_BITS) / SCALE_DIVISOR);
   localparam logic [PL_BITS-1:0]  DIV_V  = PL_BITS'(SCALE_DIVISOR);

   logic adv;

   // stage 1: product
   logic                 v1_ff;
   ctl_type              ctl1_ff;
   logic [PROD_BITS-1:0] prod1_ff;
   // stage 2: range flag and quotient estimate
   logic                 v2_ff;
   ctl_type              ctl2_ff;
   logic                 big2_ff;
   logic [PL_BITS-1:0]   pl2_ff;
   logic [EST_BITS-1:0]  est2_ff;
   // stage 3: estimate times divisor
   logic                 v3_ff;
   ctl_type              ctl3_ff;
   logic                 big3_ff;
   logic [PL_BITS-1:0]   pl3_ff;
   logic [7:0]           qe3_ff;
   logic [PL_BITS-1:0]   qd3_ff;
   // result register
   logic                   out_v_ff;
   logic                   trig_ff;
   logic                   res_ff;
   status_type             status_ff;
   logic [DIST_BITS-1:0]   dist_ff;
   logic [DIST_BITS-1:0]   led_ff;
   logic [DIST_BITS-1:0]   disp_ff;

   logic [EXT_BITS-1:0]  prod_x;
   logic [PL_BITS-1:0]   pl_in;
   logic [7:0]           qe_in;
   logic [PL_BITS-1:0]   rem;
   logic [8:0]           quot;
   logic [9:0]           sum;
   logic [DIST_BITS-1:0] dist_in;

   assign adv      = !out_v_ff || out_ready;
   assign in_ready = adv;

   always_comb begin
      prod_x  = EXT_BITS'(prod1_ff);
      pl_in   = PL_BITS'(prod_x);
      qe_in   = est2_ff[PL_BITS+7:PL_BITS];
      rem     = pl3_ff - qd3_ff;
      quot    = {1'b0, qe3_ff} + 9'(rem >= DIV_V);
      sum     = 10'(cfg.dist_offset) + 10'(quot);
      dist_in = (big3_ff || sum > 10'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctl1_ff  <= in_ctl;
         prod1_ff <= PROD_BITS'(in_width) * PROD_BITS'(cfg.scale_mult);
         ctl2_ff  <= ctl1_ff;
         big2_ff  <= (prod_x >= LIM_X);
         pl2_ff   <= pl_in;
         est2_ff  <= EST_BITS'(pl_in) * EST_BITS'(RECIP);
         ctl3_ff  <= ctl2_ff;
         big3_ff  <= big2_ff;
         pl3_ff   <= pl2_ff;
         qe3_ff   <= qe_in;
         qd3_ff   <= PL_BITS'(qe_in) * DIV_V;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
         disp_ff  <= LED_OFF;
      end else if (adv) begin
         v1_ff    <= in_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         out_v_ff <= v3_ff;
         if (v3_ff) begin
            case (ctl3_ff.kind)
               KIND_RANGE:   disp_ff <= ~dist_in;
               KIND_SHORT:   disp_ff <= LED_OFF;
               KIND_TIMEOUT: disp_ff <= LED_NO_ECHO;
               default:      disp_ff <= disp_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv && v3_ff) begin
         trig_ff <= ctl3_ff.trig;
         case (ctl3_ff.kind)
            KIND_RANGE: begin
               res_ff    <= 1'b1;
               status_ff <= ST_RANGE;
               dist_ff   <= dist_in;
               led_ff    <= ~dist_in;
            end
            KIND_SHORT: begin
               res_ff    <= 1'b1;
               status_ff <= ST_SHORT;
               dist_ff   <= '0;
               led_ff    <= LED_OFF;
            end
            KIND_TIMEOUT: begin
               res_ff    <= 1'b1;
               status_ff <= ST_TIMEOUT;
               dist_ff   <= '0;
               led_ff    <= LED_NO_ECHO;
            end
            default: begin
               res_ff    <= 1'b0;
               status_ff <= ST_RANGE;
               dist_ff   <= '0;
               led_ff    <= disp_ff;
            end
         endcase
      end
   end

   assign out_valid    = out_v_ff;
   assign out_trigger  = trig_ff;
   assign out_result   = res_ff;
   assign out_status   = status_ff;
   assign out_distance = dist_ff;
   assign out_led      = led_ff;

endmodule

// ===== src/ultrasonic_echo_ranging_controller_unit.sv =====
// Ultrasonic echo ranging controller. Each request transfer is one 1 us tick with the
// sampled echo line; each produces exactly one response transfer with the trigger drive,
// a result flag, status, distance and the held LED byte. One tick is taken per clock
// cycle when the response side keeps up. The tick sequencer classifies the tick in the
// cycle of the transfer; the queue then hands it to the distance pipeline, which has three
// register stages (product, reciprocal estimate, estimate times divisor) before the result
// register. A four-entry queue separates sequencer and pipeline, so request transfers keep
// flowing for up to four ticks after the response side stalls. No clearing pass follows
// reset. Depends on uerc_pkg, uerc_if, uerc_front, uerc_queue and uerc_back.
module ultrasonic_echo_ranging_controller_unit #(
   parameter int COUNT_BITS    = uerc_pkg::COUNT_BITS_DEF,
   parameter int SCALE_DIVISOR = uerc_pkg::SCALE_DIVISOR_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   uerc_req_if.sink                            req_ch,
   uerc_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [uerc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [uerc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import uerc_pkg::*;

   localparam int DATA_BITS = CTL_BITS + COUNT_BITS;

   cfg_type               cfg_ff;
   logic                  accept;
   ctl_type               f_ctl;
   logic [COUNT_BITS-1:0] f_width;
   logic                  q_full;
   logic                  q_not_empty;
   logic [DATA_BITS-1:0]  q_data;
   logic                  b_ready;
   ctl_type               b_ctl;
   logic [COUNT_BITS-1:0] b_width;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.holdoff_ticks <= HOLDOFF_RST;
         cfg_ff.trigger_ticks <= TRIGGER_RST;
         cfg_ff.min_width     <= MIN_WIDTH_RST;
         cfg_ff.timeout_ticks <= TIMEOUT_RST;
         cfg_ff.scale_mult    <= MULT_RST;
         cfg_ff.dist_offset   <= OFFSET_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_HOLDOFF:   cfg_ff.holdoff_ticks <= csr_wdata;
            CSR_TRIGGER:   cfg_ff.trigger_ticks <= csr_wdata[7:0];
            CSR_MIN_WIDTH: cfg_ff.min_width     <= csr_wdata;
            CSR_TIMEOUT:   cfg_ff.timeout_ticks <= csr_wdata;
            CSR_MULT:      cfg_ff.scale_mult    <= csr_wdata[11:0];
            CSR_OFFSET:    cfg_ff.dist_offset   <= csr_wdata[7:0];
            default:       cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;

   uerc_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .step  (accept),
      .echo  (req_ch.echo_level),
      .ctl   (f_ctl),
      .width (f_width)
   );

   uerc_queue #(
      .DATA_BITS(DATA_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data ({f_ctl, f_width}),
      .pop       (q_not_empty && b_ready),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   assign b_ctl   = ctl_type'(q_data[DATA_BITS-1 -: CTL_BITS]);
   assign b_width = q_data[COUNT_BITS-1:0];

   uerc_back #(
      .COUNT_BITS    (COUNT_BITS),
      .SCALE_DIVISOR (SCALE_DIVISOR)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (q_not_empty),
      .in_ctl       (b_ctl),
      .in_width     (b_width),
      .in_ready     (b_ready),
      .out_valid    (rsp_ch.valid),
      .out_ready    (rsp_ch.ready),
      .out_trigger  (rsp_ch.trigger_level),
      .out_result   (rsp_ch.result_valid),
      .out_status   (rsp_ch.status),
      .out_distance (rsp_ch.distance),
      .out_led      (rsp_ch.led_pattern)
   );

endmodule

// ===== src/uerc_checker.sv =====
// port-level checks for the echo ranging controller, bound to the top level
// depends on uerc_pkg and ultrasonic_echo_ranging_controller_unit
module uerc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_trigger_level,
   input logic                                rsp_result_valid,
   input logic [uerc_pkg::STATUS_BITS-1:0]    rsp_status,
   input logic [uerc_pkg::DIST_BITS-1:0]      rsp_distance,
   input logic [uerc_pkg::DIST_BITS-1:0]      rsp_led_pattern
);
   import uerc_pkg::*;

   // stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_valid)
         && $stable(rsp_status) && $stable(rsp_distance) && $stable(rsp_led_pattern)
         && $stable(rsp_trigger_level))
      else $error("response payload changed while stalled");

   // ticks without a result carry no status and no distance
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_valid |-> rsp_status == ST_RANGE && rsp_distance == '0)
      else $error("status or distance set without a result");

   // in-range result shows the inverted distance on the display
   a_led_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_valid && rsp_status == ST_RANGE
         |-> rsp_led_pattern == ~rsp_distance)
      else $error("display byte does not match distance");

   // failed results carry no distance and their fixed display byte
   a_led_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_valid && rsp_status != ST_RANGE
         |-> rsp_distance == '0
            && ((rsp_status == ST_SHORT && rsp_led_pattern == LED_OFF)
               || (rsp_status == ST_TIMEOUT && rsp_led_pattern == LED_NO_ECHO)))
      else $error("bad status or display byte on a failed result");

   // display byte only changes on a result
   a_led_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready ##1 rsp_valid && !rsp_result_valid
         |-> rsp_led_pattern == $past(rsp_led_pattern))
      else $error("display byte changed without a result");

endmodule

bind ultrasonic_echo_ranging_controller_unit uerc_checker u_uerc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_trigger_level (rsp_ch.trigger_level),
   .rsp_result_valid  (rsp_ch.result_valid),
   .rsp_status        (rsp_ch.status),
   .rsp_distance      (rsp_ch.distance),
   .rsp_led_pattern   (rsp_ch.led_pattern)
);
